// ===== hdl/bbr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared codes and widths for the BIER bitstring replicator.
// ----------------------------------------------------------------------------
package bbr_pkg;

  localparam int RIDX_W      = 6;
  localparam int PORT_BITS   = 32;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = 6;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_FWD   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_COPY  = 2'd0,
    KIND_LOCAL = 2'd1,
    KIND_DROP  = 2'd2
  } kind_t;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_APPLY = 1'b1
  } bk_state_t;

  localparam logic REG_LOCAL_ID = 1'b0;

endpackage

// ===== hdl/bbr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_front
// Input stage: takes items, drops those without effect, packs commands.
// ----------------------------------------------------------------------------
module bbr_front import bbr_pkg::*; #(
  parameter int BITSTRING_BITS = 32,
  parameter int IW             = $clog2(BITSTRING_BITS),
  parameter int CW             = 1 + IW + BITSTRING_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [RIDX_W-1:0]    in_entry_index,
  input  logic [PORT_BITS-1:0] in_entry_mask,
  input  logic [PORT_BITS-1:0] in_packet_bits,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [CW-1:0]        q_data
);

  logic                            fv_r, fv_nxt;
  logic [CW-1:0]                   cmd_r;
  logic                            accept, keep;
  logic [BITSTRING_BITS+PORT_BITS-1:0] mask_ext, bits_ext;
  logic [BITSTRING_BITS-1:0]       mask_v, bits_v;
  logic [RIDX_W-1:0]               idx_m1;
  logic [CW-1:0]                   cmd_nxt;

  assign in_stall = fv_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = fv_r && !q_full;
  assign q_data   = cmd_r;

  assign mask_ext = {{BITSTRING_BITS{1'b0}}, in_entry_mask};
  assign bits_ext = {{BITSTRING_BITS{1'b0}}, in_packet_bits};
  assign mask_v   = mask_ext[BITSTRING_BITS-1:0];
  assign bits_v   = bits_ext[BITSTRING_BITS-1:0];
  assign idx_m1   = in_entry_index - RIDX_W'(1);

  always_comb begin
    if (in_operation == OP_WRITE) begin
      keep    = (in_entry_index != '0) &&
                ({1'b0, in_entry_index} <= (RIDX_W+1)'(BITSTRING_BITS));
      cmd_nxt = {OP_WRITE, idx_m1[IW-1:0], mask_v};
    end else begin
      keep    = (bits_v != '0);
      cmd_nxt = {OP_FWD, {IW{1'b0}}, bits_v};
    end
  end

  always_comb begin
    if (accept) begin
      fv_nxt = keep;
    end else begin
      fv_nxt = fv_r && !q_push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ===== hdl/bbr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module bbr_queue import bbr_pkg::*; #(
  parameter int W = 39
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] head
);

  logic [W-1:0] slot_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== hdl/bbr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_back
// Forwarding table and bit scanner; one result per table read.
// ----------------------------------------------------------------------------
module bbr_back import bbr_pkg::*; #(
  parameter int BITSTRING_BITS = 32,
  parameter int IW             = $clog2(BITSTRING_BITS),
  parameter int CW             = 1 + IW + BITSTRING_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  logic [CW-1:0]        q_head,
  output logic                 q_pop,
  input  logic [RIDX_W-1:0]    local_id,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_kind,
  output logic [RIDX_W-1:0]    out_router_index,
  output logic [PORT_BITS-1:0] out_copy_bits,
  output logic                 out_last
);

  bk_state_t                 state_r, state_nxt;
  logic [BITSTRING_BITS-1:0] mask_mem [BITSTRING_BITS];
  logic [BITSTRING_BITS-1:0] ev_r, ev_nxt;
  logic [BITSTRING_BITS-1:0] rd_data_r;
  logic [BITSTRING_BITS-1:0] work_r, work_nxt;
  logic [IW-1:0]             pos_r, pos_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;

  logic                      ov_r, ov_nxt;
  kind_t                     kind_r;
  logic [RIDX_W-1:0]         ridx_r;
  logic [PORT_BITS-1:0]      copy_r;
  logic                      last_r;

  logic                      h_op;
  logic [IW-1:0]             h_addr;
  logic [BITSTRING_BITS-1:0] h_data;
  logic                      wr_en, rd_en;
  logic [IW-1:0]             rd_addr;
  logic                      load;
  logic [BITSTRING_BITS-1:0] bit_sel, used_mask, new_work, copy_v;
  logic [BITSTRING_BITS+PORT_BITS-1:0] copy_ext;
  logic [6:0]                ridx7;
  logic                      is_local, ent_ok, res_last;
  kind_t                     kind_v;
  logic [IW-1:0]             low_head, low_new;

  assign {h_op, h_addr, h_data} = q_head;

  always_comb begin
    low_head = '0;
    low_new  = '0;
    for (int i = BITSTRING_BITS - 1; i >= 0; i--) begin
      if (h_data[i]) low_head = IW'(i);
      if (new_work[i]) low_new = IW'(i);
    end
  end

  // result for the bit at pos_r, using the mask held from the latest table read
  always_comb begin
    bit_sel   = '0;
    bit_sel[pos_r] = 1'b1;
    ridx7     = 7'(pos_r) + 7'd1;
    is_local  = (ridx7 == {1'b0, local_id});
    ent_ok    = ev_r[pos_r];
    used_mask = ent_ok ? rd_data_r : '0;
    new_work  = work_r & ~used_mask & ~bit_sel;
    res_last  = (new_work == '0) || (cnt_r == CNT_W'(MAX_RESULTS - 1));
    copy_v    = '0;
    if (is_local) begin
      kind_v = KIND_LOCAL;
    end else if (ent_ok) begin
      kind_v = KIND_COPY;
      copy_v = work_r & rd_data_r;
    end else begin
      kind_v = KIND_DROP;
    end
    copy_ext  = {{PORT_BITS{1'b0}}, copy_v};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty && h_op == OP_FWD) state_nxt = BK_APPLY;
      end
      BK_APPLY: begin
        if (load && res_last) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = pos_r;
    load     = 1'b0;
    ev_nxt   = ev_r;
    work_nxt = work_r;
    pos_nxt  = pos_r;
    cnt_nxt  = cnt_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (h_op == OP_WRITE) begin
            wr_en          = 1'b1;
            ev_nxt[h_addr] = 1'b1;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = low_head;
            pos_nxt  = low_head;
            work_nxt = h_data;
            cnt_nxt  = '0;
          end
        end
      end
      BK_APPLY: begin
        load = !ov_r || !out_stall;
        if (load && !res_last) begin
          rd_en    = 1'b1;
          rd_addr  = low_new;
          pos_nxt  = low_new;
          work_nxt = new_work;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      default: ;
    endcase
    ov_nxt = load ? 1'b1 : (ov_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ev_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ev_r    <= ev_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    pos_r  <= pos_nxt;
    cnt_r  <= cnt_nxt;
    if (load) begin
      kind_r <= kind_v;
      ridx_r <= ridx7[RIDX_W-1:0];
      copy_r <= copy_ext[PORT_BITS-1:0];
      last_r <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mask_mem[h_addr] <= h_data;
    end
    if (rd_en) begin
      rd_data_r <= mask_mem[rd_addr];
    end
  end

  assign out_valid        = ov_r;
  assign out_kind         = kind_r;
  assign out_router_index = ridx_r;
  assign out_copy_bits    = copy_r;
  assign out_last         = last_r;

`ifndef SYNTHESIS
  a_apply_bit_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_APPLY) |-> work_r[pos_r])
    else $error("scan position not set in working bitstring");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == BK_IDLE))
    else $error("table write outside idle");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_APPLY) |-> (cnt_r < CNT_W'(MAX_RESULTS)))
    else $error("result count past limit");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res_last) |=> (state_r == BK_IDLE))
    else $error("scan continues after last result");
`endif

endmodule

// ===== hdl/bier_bitstring_replicator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bier_bitstring_replicator
// BIER bit-index forwarding: table writes and per-bit packet replication.
// ----------------------------------------------------------------------------
// A table write is applied by the scanner while it is idle. A forward item
// starts with a table read at its lowest set bit, then yields one result per
// scanned bit; items with no result (empty bitstring, out-of-range write
// index) are dropped at the input stage. Results are paced by the loop
// through the table's registered read port: the next scan position depends
// on the mask just read. Inputs pass a register stage and a two-entry queue
// before the scanner, and the block keeps taking items while the scanner
// works until that queue fills. The mask table has no reset; only its valid
// bits clear.
// ----------------------------------------------------------------------------
module bier_bitstring_replicator import bbr_pkg::*; #(
  parameter int BITSTRING_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic [RIDX_W-1:0]     in_entry_index,
  input  logic [PORT_BITS-1:0]  in_entry_mask,
  input  logic [PORT_BITS-1:0]  in_packet_bits,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [RIDX_W-1:0]     out_router_index,
  output logic [PORT_BITS-1:0]  out_copy_bits,
  output logic                  out_last
);

  localparam int IW = $clog2(BITSTRING_BITS);
  localparam int CW = 1 + IW + BITSTRING_BITS;

  logic [RIDX_W-1:0] local_id_r, local_id_nxt;
  logic              reg_hit;
  logic              q_push, q_full, q_pop, q_empty;
  logic [CW-1:0]     push_data, head;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_LOCAL_ID);

  always_comb begin
    local_id_nxt = local_id_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      local_id_nxt = pwdata[RIDX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(CFG_DATA_W-RIDX_W){1'b0}}, local_id_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_id_r <= '0;
    end else begin
      local_id_r <= local_id_nxt;
    end
  end

  bbr_front #(
    .BITSTRING_BITS(BITSTRING_BITS),
    .IW            (IW),
    .CW            (CW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_entry_index(in_entry_index),
    .in_entry_mask (in_entry_mask),
    .in_packet_bits(in_packet_bits),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (push_data)
  );

  bbr_queue #(
    .W(CW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head)
  );

  bbr_back #(
    .BITSTRING_BITS(BITSTRING_BITS),
    .IW            (IW),
    .CW            (CW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (head),
    .q_pop           (q_pop),
    .local_id        (local_id_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_router_index(out_router_index),
    .out_copy_bits   (out_copy_bits),
    .out_last        (out_last)
  );

endmodule
